FILE: rtl/plse_pkg.sv
`default_nettype none
package plse_pkg;

  // Input command codes
  localparam logic [1:0] CMD_MOVE     = 2'd0;
  localparam logic [1:0] CMD_PEN_DOWN = 2'd1;
  localparam logic [1:0] CMD_PEN_UP   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_CLIENT_RIGHT  = 2'd0;
  localparam logic [1:0] REG_CLIENT_BOTTOM = 2'd1;
  localparam logic [1:0] REG_MIN_DIST_SQ   = 2'd2;
  localparam logic [1:0] REG_HALF_WIDTH    = 2'd3;

  // Register reset values
  localparam logic [15:0] CLIENT_RIGHT_RST  = 16'd900;
  localparam logic [15:0] CLIENT_BOTTOM_RST = 16'd700;
  localparam logic [11:0] MIN_DIST_SQ_RST   = 12'd4;
  localparam logic [12:0] HALF_WIDTH_RST    = 13'd82;

  // Shared divider and root widths
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_W    = 64;

  typedef enum logic [1:0] {
    DIV_NX,
    DIV_NY,
    DIV_PX,
    DIV_PY
  } div_sel_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               minus_side;
    logic               last_of_pair;
  } out_item_t;

  typedef struct packed {
    logic     latch_in;
    logic     pen_down;
    logic     pen_up;
    logic     sq_load;
    logic     sq_acc;
    logic     sq_tan;
    logic     keep_point;
    logic     count_point;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     sqrt_start;
    logic     mul_load;
    logic     mul_use_dx;
    logic     win_store;
    logic     win_shift;
    logic     out_load;
    logic     out_minus;
  } plse_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pen_is_down;
    logic       has_last;
    logic       too_close;
    logic       at_limit;
    logic       fill_full;
    logic       len_zero;
    logic       div_done;
    logic       sqrt_done;
    logic       out_free;
  } plse_sts_t;

endpackage
`default_nettype wire

FILE: rtl/plse_div.sv
`default_nettype none
module plse_div (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire [plse_pkg::DIV_NUM_W-1:0] num,
  input  wire [plse_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [plse_pkg::DIV_NUM_W-1:0] quo
);
  import plse_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);
  localparam logic [CW-1:0] LAST = CW'(DIV_NUM_W - 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] qr;
  logic [DIV_DEN_W-1:0] dr;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // One restoring step: shift in a numerator bit, subtract when it fits
  assign trial = {rem, qr[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, dr};
  assign ge    = trial >= {1'b0, dr};
  assign quo   = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qr   <= num;
        dr   <= den;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        qr  <= {qr[DIV_NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/plse_sqrt.sv
`default_nettype none
module plse_sqrt (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire [plse_pkg::SQRT_W-1:0] rad,
  output logic                       done,
  output logic [plse_pkg::SQRT_W/2-1:0] root
);
  import plse_pkg::*;

  localparam int CW = $clog2(SQRT_W / 2);
  localparam logic [CW-1:0] LAST = CW'(SQRT_W / 2 - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [SQRT_W-1:0] v;
  logic [SQRT_W-1:0] r;
  logic [SQRT_W-1:0] bitm;
  logic [SQRT_W-1:0] tst;

  // Digit-by-digit root, one result bit per cycle
  assign tst  = r + bitm;
  assign root = r[SQRT_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= rad;
        r    <= '0;
        bitm <= {2'b01, {(SQRT_W-2){1'b0}}};
      end else if (busy) begin
        if (v >= tst) begin
          v <= v - tst;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/plse_ctrl.sv
`default_nettype none
module plse_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  plse_pkg::plse_sts_t sts,
  output plse_pkg::plse_ctl_t ctl
);
  import plse_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_DECODE   = 23'h000002,
    S_DIST_A   = 23'h000004,
    S_DIST_B   = 23'h000008,
    S_DIST_C   = 23'h000010,
    S_KEEP     = 23'h000020,
    S_NX_START = 23'h000040,
    S_NX_WAIT  = 23'h000080,
    S_NY_START = 23'h000100,
    S_NY_WAIT  = 23'h000200,
    S_WIN      = 23'h000400,
    S_TAN_A    = 23'h000800,
    S_TAN_B    = 23'h001000,
    S_TAN_C    = 23'h002000,
    S_SQ_START = 23'h004000,
    S_SQ_WAIT  = 23'h008000,
    S_PX_MUL   = 23'h010000,
    S_PX_START = 23'h020000,
    S_PX_WAIT  = 23'h040000,
    S_PY_MUL   = 23'h080000,
    S_PY_START = 23'h100000,
    S_PY_WAIT  = 23'h200000,
    S_OUT      = 23'h400000
  } state_t;

  state_t state, state_next;
  logic   second;
  logic   second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // Sequence one item through the datapath
  always_comb begin
    state_next  = state;
    second_next = second;
    ctl         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (sts.cmd == CMD_PEN_DOWN) begin
          ctl.pen_down = 1'b1;
        end else if (sts.cmd == CMD_PEN_UP) begin
          ctl.pen_up = 1'b1;
        end else if (sts.cmd == CMD_MOVE && sts.pen_is_down) begin
          state_next = sts.has_last ? S_DIST_A : S_KEEP;
        end
      end
      S_DIST_A: begin
        ctl.sq_load = 1'b1;
        state_next  = S_DIST_B;
      end
      S_DIST_B: begin
        ctl.sq_acc = 1'b1;
        state_next = S_DIST_C;
      end
      S_DIST_C: begin
        state_next = sts.too_close ? S_IDLE : S_KEEP;
      end
      S_KEEP: begin
        ctl.keep_point = 1'b1;
        if (sts.at_limit) begin
          state_next = S_IDLE;
        end else begin
          ctl.count_point = 1'b1;
          state_next      = S_NX_START;
        end
      end
      S_NX_START: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_NX;
        state_next    = S_NX_WAIT;
      end
      S_NX_WAIT: begin
        ctl.div_sel = DIV_NX;
        if (sts.div_done) begin
          ctl.div_capture = 1'b1;
          state_next      = S_NY_START;
        end
      end
      S_NY_START: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_NY;
        state_next    = S_NY_WAIT;
      end
      S_NY_WAIT: begin
        ctl.div_sel = DIV_NY;
        if (sts.div_done) begin
          ctl.div_capture = 1'b1;
          state_next      = S_WIN;
        end
      end
      S_WIN: begin
        if (sts.fill_full) begin
          state_next = S_TAN_A;
        end else begin
          ctl.win_store = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TAN_A: begin
        ctl.sq_tan  = 1'b1;
        ctl.sq_load = 1'b1;
        state_next  = S_TAN_B;
      end
      S_TAN_B: begin
        ctl.sq_tan = 1'b1;
        ctl.sq_acc = 1'b1;
        state_next = S_TAN_C;
      end
      S_TAN_C: begin
        if (sts.len_zero) begin
          ctl.win_shift = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_SQ_START;
        end
      end
      S_SQ_START: begin
        ctl.sqrt_start = 1'b1;
        state_next     = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sqrt_done) state_next = S_PX_MUL;
      end
      S_PX_MUL: begin
        ctl.mul_load = 1'b1;
        state_next   = S_PX_START;
      end
      S_PX_START: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_PX;
        state_next    = S_PX_WAIT;
      end
      S_PX_WAIT: begin
        ctl.div_sel = DIV_PX;
        if (sts.div_done) begin
          ctl.div_capture = 1'b1;
          state_next      = S_PY_MUL;
        end
      end
      S_PY_MUL: begin
        ctl.mul_load   = 1'b1;
        ctl.mul_use_dx = 1'b1;
        state_next     = S_PY_START;
      end
      S_PY_START: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_PY;
        state_next    = S_PY_WAIT;
      end
      S_PY_WAIT: begin
        ctl.div_sel = DIV_PY;
        if (sts.div_done) begin
          ctl.div_capture = 1'b1;
          second_next     = 1'b0;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        // Hand both vertices to the output register, then shift the window
        if (sts.out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_minus = second;
          second_next   = 1'b1;
          if (second) begin
            ctl.win_shift = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/plse_dp.sv
`default_nettype none
module plse_dp #(
  parameter int STROKE_POINT_LIMIT = 65536
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_index,
  input  wire [15:0]          cfg_data,
  input  plse_pkg::in_item_t  in_data,
  input  plse_pkg::plse_ctl_t ctl,
  output plse_pkg::plse_sts_t sts,
  output logic                out_valid,
  input  wire                 out_ready,
  output plse_pkg::out_item_t out_data
);
  import plse_pkg::*;

  localparam int SPW = $clog2(STROKE_POINT_LIMIT + 1);

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sh7fff;
    if (v < -34'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Configuration
  logic [15:0] client_right, client_bottom;
  logic [11:0] min_dist_sq;
  logic [12:0] half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_right  <= CLIENT_RIGHT_RST;
      client_bottom <= CLIENT_BOTTOM_RST;
      min_dist_sq   <= MIN_DIST_SQ_RST;
      half_width    <= HALF_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIENT_RIGHT:  client_right  <= cfg_data;
        REG_CLIENT_BOTTOM: client_bottom <= cfg_data;
        REG_MIN_DIST_SQ:   min_dist_sq   <= cfg_data[11:0];
        REG_HALF_WIDTH:    half_width    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Stroke state
  in_item_t           item;
  logic               pen_is_down, has_last;
  logic [15:0]        last_x, last_y;
  logic [SPW-1:0]     stroke_pts;
  logic [1:0]         fill;
  logic signed [15:0] w0, w1, w2, w3;
  logic signed [15:0] nx, ny;

  always_ff @(posedge clk) begin
    if (ctl.latch_in) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_is_down <= 1'b0;
      has_last    <= 1'b0;
      last_x      <= '0;
      last_y      <= '0;
      stroke_pts  <= '0;
      fill        <= '0;
      w0 <= '0;
      w1 <= '0;
      w2 <= '0;
      w3 <= '0;
    end else begin
      if (ctl.pen_down) begin
        pen_is_down <= 1'b1;
        has_last    <= 1'b0;
        fill        <= '0;
        stroke_pts  <= '0;
      end
      if (ctl.pen_up) pen_is_down <= 1'b0;
      if (ctl.keep_point) begin
        last_x   <= item.x_pos;
        last_y   <= item.y_pos;
        has_last <= 1'b1;
      end
      if (ctl.count_point) stroke_pts <= stroke_pts + 1'b1;
      if (ctl.win_store) begin
        if (fill == 2'd0) begin
          w0   <= nx;
          w1   <= ny;
          fill <= 2'd1;
        end else begin
          w2   <= nx;
          w3   <= ny;
          fill <= 2'd2;
        end
      end
      if (ctl.win_shift) begin
        w0 <= w2;
        w1 <= w3;
        w2 <= nx;
        w3 <= ny;
      end
    end
  end

  // Differences for the distance test and the tangent
  logic signed [16:0] ddx, ddy, tdx, tdy, sq_op;
  logic signed [33:0] sq_prod;
  logic [31:0]        sq_reg;
  logic [32:0]        acc;

  assign ddx     = $signed({1'b0, item.x_pos}) - $signed({1'b0, last_x});
  assign ddy     = $signed({1'b0, item.y_pos}) - $signed({1'b0, last_y});
  assign tdx     = {nx[15], nx} - {w0[15], w0};
  assign tdy     = {ny[15], ny} - {w1[15], w1};
  assign sq_op   = ctl.sq_tan ? (ctl.sq_load ? tdx : tdy) : (ctl.sq_load ? ddx : ddy);
  assign sq_prod = sq_op * sq_op;

  // Accumulate the two squares: load the first, then add the second to it
  always_ff @(posedge clk) begin
    if (ctl.sq_load) sq_reg <= sq_prod[31:0];
    if (ctl.sq_acc) acc <= {1'b0, sq_reg} + {1'b0, sq_prod[31:0]};
  end

  // Offset magnitude product
  logic [15:0] mag_dx, mag_dy;
  logic [16:0] neg_dx, neg_dy;
  logic [28:0] mul_reg;

  assign neg_dx = -tdx;
  assign neg_dy = -tdy;
  assign mag_dx = tdx[16] ? neg_dx[15:0] : tdx[15:0];
  assign mag_dy = tdy[16] ? neg_dy[15:0] : tdy[15:0];

  always_ff @(posedge clk) begin
    if (ctl.mul_load) mul_reg <= (ctl.mul_use_dx ? mag_dx : mag_dy) * half_width;
  end

  // Square root of the squared tangent length
  logic        sqrt_done;
  logic [31:0] s_root;

  plse_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.sqrt_start),
    .rad  ({3'b0, acc, 28'b0}),
    .done (sqrt_done),
    .root (s_root)
  );

  // Shared divider operands
  logic [15:0]          dvx, dvy;
  logic [31:0]          num_x, num_y;
  logic [47:0]          num_p;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quo;

  assign dvx   = (client_right >= 16'd2) ? client_right - 16'd1 : 16'd1;
  assign dvy   = (client_bottom >= 16'd2) ? client_bottom - 16'd1 : 16'd1;
  assign num_x = {1'b0, item.x_pos, 15'b0} + {17'b0, dvx[15:1]};
  assign num_y = {1'b0, item.y_pos, 15'b0} + {17'b0, dvy[15:1]};
  assign num_p = {5'b0, mul_reg, 14'b0} + {17'b0, s_root[31:1]};

  always_comb begin
    case (ctl.div_sel)
      DIV_NX: begin
        div_num = {16'b0, num_x};
        div_den = {16'b0, dvx};
      end
      DIV_NY: begin
        div_num = {16'b0, num_y};
        div_den = {16'b0, dvy};
      end
      default: begin
        div_num = num_p;
        div_den = s_root;
      end
    endcase
  end

  plse_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  // Capture quotients with sign and saturation applied
  logic signed [31:0] px, py;
  logic signed [33:0] q_ext;
  logic signed [31:0] q_mag;

  assign q_ext = $signed({2'b0, quo[31:0]});
  assign q_mag = $signed({2'b0, quo[29:0]});

  always_ff @(posedge clk) begin
    if (ctl.div_capture) begin
      case (ctl.div_sel)
        DIV_NX: nx <= sat16(q_ext - 34'sd16384);
        DIV_NY: ny <= sat16(34'sd16384 - q_ext);
        DIV_PX: px <= (!tdy[16] && tdy != 17'sd0) ? -q_mag : q_mag;
        default: py <= tdx[16] ? -q_mag : q_mag;
      endcase
    end
  end

  // Output register
  logic signed [33:0] cx, cy, ox, oy;
  assign cx = {{18{w2[15]}}, w2};
  assign cy = {{18{w3[15]}}, w3};
  assign ox = {{2{px[31]}}, px};
  assign oy = {{2{py[31]}}, py};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data.vertex_x     <= ctl.out_minus ? sat16(cx - ox) : sat16(cx + ox);
      out_data.vertex_y     <= ctl.out_minus ? sat16(cy - oy) : sat16(cy + oy);
      out_data.minus_side   <= ctl.out_minus;
      out_data.last_of_pair <= ctl.out_minus;
    end
  end

  // Status to the controller
  always_comb begin
    sts.cmd         = item.cmd;
    sts.pen_is_down = pen_is_down;
    sts.has_last    = has_last;
    sts.too_close   = acc < {21'b0, min_dist_sq};
    sts.at_limit    = stroke_pts >= SPW'(STROKE_POINT_LIMIT);
    sts.fill_full   = fill[1];
    sts.len_zero    = acc == 33'd0;
    sts.div_done    = div_done;
    sts.sqrt_done   = sqrt_done;
    sts.out_free    = !out_valid || out_ready;
  end
endmodule
`default_nettype wire

FILE: rtl/polyline_stroke_extruder.sv
// Polyline stroke extruder: turns pen-down, pen-up and pointer-move items
// into pairs of triangle strip vertices in signed Q2.14.
// Input channel in_valid/in_ready/in_data carries cmd, x_pos, y_pos; output
// channel out_valid/out_ready/out_data carries vertex_x, vertex_y,
// minus_side, last_of_pair. A transfer happens when valid and ready are high.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
// Items are handled one at a time. Pen commands and dropped moves skip the
// divider and the square root. A kept move runs the shared 48-step restoring
// divider twice for normalization; when it completes a pair it also runs the
// 32-step square root and the divider twice more for the offset.
// The output register holds a finished vertex while the receiver stalls;
// the controller waits for it to drain before loading the next vertex, and
// takes a new input as soon as the second vertex of a pair is loaded.
// Synchronous reset restores the register defaults, lifts the pen and
// clears the stroke and window state; no clearing pass is needed.
`default_nettype none
module polyline_stroke_extruder #(
  parameter int STROKE_POINT_LIMIT = 65536
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  plse_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output plse_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_index,
  input  wire [15:0]          cfg_data
);
  import plse_pkg::*;

  plse_ctl_t ctl;
  plse_sts_t sts;

  plse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  plse_dp #(
    .STROKE_POINT_LIMIT(STROKE_POINT_LIMIT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );
endmodule
`default_nettype wire
